@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the line rasterizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ hw/rtl/lr_pkg.sv @@
// Types and constants of the line rasterizer.
package lr_pkg;

    localparam int COORD_BITS  = 6;
    localparam int CANVAS_W    = 7;
    localparam int ERR_W       = COORD_BITS + 3;
    localparam int E2_W        = ERR_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic [CANVAS_W-1:0] canvas_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam canvas_t CANVAS_WIDTH_RESET  = canvas_t'(60);
    localparam canvas_t CANVAS_HEIGHT_RESET = canvas_t'(20);

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } in_item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   visible;
        logic   last_pixel;
    } out_item_t;

    // Classified line command: endpoints, step magnitudes, directions, initial error
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t dx;
        coord_t dy_mag;
        logic   x_neg;
        logic   y_neg;
        err_t   err0;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

endpackage

@@ hw/rtl/line_rasterizer.sv @@
// Top level of the line rasterizer: canvas registers, front end, queue and stepper.
//
// Each input item is a line from (start_x, start_y) to (end_x, end_y); the block
// emits every pixel of the line in order, the end pixel flagged last_pixel, each
// pixel flagged visible when it lies inside the canvas window. A line whose
// larger coordinate span is n gives n + 1 pixels at one pixel per cycle while
// out_stall is low; the stepper loads the item, then emits the pixels. Its
// single error-term update per pixel sets the rate. The front end and a
// two-entry command queue take up to three further items while a line is drawn.
// Items pass the front-end register, queue and stepper to a registered output.
// Canvas registers are written through cfg_we/cfg_index/cfg_data, reset 60 by 20.
module line_rasterizer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lr_pkg::in_item_t                     in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lr_pkg::out_item_t                    out_item,
    input  logic                                 cfg_we,
    input  logic [lr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lr_pkg::CANVAS_W-1:0]          cfg_data
);
    import lr_pkg::*;

    `include "assert_macros.svh"

    canvas_t       canvas_width_reg, canvas_width_next;
    canvas_t       canvas_height_reg, canvas_height_next;
    logic          push, pop;
    cmd_t          front_cmd, head_cmd;
    queue_status_t q_status;
    back_status_t  b_status;

    always_comb
    begin
        canvas_width_next  = canvas_width_reg;
        canvas_height_next = canvas_height_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CANVAS_WIDTH:  canvas_width_next  = cfg_data;
                REG_CANVAS_HEIGHT: canvas_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_WIDTH_RESET;
            canvas_height_reg <= CANVAS_HEIGHT_RESET;
        end
        else
        begin
            canvas_width_reg  <= canvas_width_next;
            canvas_height_reg <= canvas_height_next;
        end
    end

    lr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .queue_full (q_status.full),
        .push       (push),
        .cmd        (front_cmd)
    );

    lr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    lr_stepper u_stepper (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_avail     (!q_status.empty),
        .cmd           (head_cmd),
        .pop           (pop),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item),
        .status        (b_status)
    );

    `ASSERT_NEVER(a_queue_full_and_empty, clk, rst_n, q_status.full && q_status.empty)
    `ASSERT_IMPLIES(a_more_pixels_pending, clk, rst_n, out_valid && !out_item.last_pixel, b_status.busy)
    `ASSERT_IMPLIES(a_visible_in_window, clk, rst_n, out_valid && out_item.visible, (canvas_t'(out_item.pixel_x) < canvas_width_reg) && (canvas_t'(out_item.pixel_y) < canvas_height_reg))

endmodule

@@ hw/rtl/lr_front.sv @@
// Front end: accepts line items and classifies them into step commands.
module lr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lr_pkg::in_item_t in_item,
    input  logic             queue_full,
    output logic             push,
    output lr_pkg::cmd_t     cmd
);
    import lr_pkg::*;

    logic   valid_reg, valid_next;
    cmd_t   cmd_reg, cmd_next;
    logic   accept;
    coord_t dx, dy_mag;

    assign in_stall = valid_reg && queue_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !queue_full;
    assign cmd      = cmd_reg;

    always_comb
    begin
        dx = (in_item.end_x >= in_item.start_x) ? in_item.end_x - in_item.start_x
                                                : in_item.start_x - in_item.end_x;
        dy_mag = (in_item.end_y >= in_item.start_y) ? in_item.end_y - in_item.start_y
                                                    : in_item.start_y - in_item.end_y;
        cmd_next.start_x = in_item.start_x;
        cmd_next.start_y = in_item.start_y;
        cmd_next.end_x   = in_item.end_x;
        cmd_next.end_y   = in_item.end_y;
        cmd_next.dx      = dx;
        cmd_next.dy_mag  = dy_mag;
        // step toward the end; equal coordinates step negative but never move
        cmd_next.x_neg   = !(in_item.start_x < in_item.end_x);
        cmd_next.y_neg   = !(in_item.start_y < in_item.end_y);
        cmd_next.err0    = err_t'({{(ERR_W-COORD_BITS){1'b0}}, dx})
                         - err_t'({{(ERR_W-COORD_BITS){1'b0}}, dy_mag});

        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

@@ hw/rtl/lr_queue.sv @@
// Short command queue between front end and stepper.
module lr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lr_pkg::cmd_t          push_cmd,
    input  logic                  pop,
    output lr_pkg::cmd_t          head_cmd,
    output lr_pkg::queue_status_t status
);
    import lr_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ hw/rtl/lr_stepper.sv @@
// Back end: Bresenham error-term stepper with a registered pixel output.
module lr_stepper (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_avail,
    input  lr_pkg::cmd_t         cmd,
    output logic                 pop,
    input  lr_pkg::canvas_t      canvas_width,
    input  lr_pkg::canvas_t      canvas_height,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lr_pkg::out_item_t    out_item,
    output lr_pkg::back_status_t status
);
    import lr_pkg::*;

    logic      busy_reg, busy_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    coord_t    cx_reg, cx_next, cy_reg, cy_next;
    coord_t    ex_reg, ex_next, ey_reg, ey_next;
    coord_t    dx_reg, dx_next, dym_reg, dym_next;
    logic      xneg_reg, xneg_next, yneg_reg, yneg_next;
    err_t      err_reg, err_next;

    logic                   advance, done, move_x, move_y;
    logic signed [E2_W-1:0] e2, dx_w, dy_w;
    err_t                   dx_e, dy_e;

    assign pop       = cmd_avail && !busy_reg;
    assign advance   = busy_reg && (!out_valid_reg || !out_stall);
    assign done      = (cx_reg == ex_reg) && (cy_reg == ey_reg);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign status.busy = busy_reg;

    // e2 = 2 * err, compared against dy (negative magnitude) and dx
    assign e2     = {err_reg, 1'b0};
    assign dx_w   = {{(E2_W-COORD_BITS){1'b0}}, dx_reg};
    assign dy_w   = -{{(E2_W-COORD_BITS){1'b0}}, dym_reg};
    assign dx_e   = {{(ERR_W-COORD_BITS){1'b0}}, dx_reg};
    assign dy_e   = -{{(ERR_W-COORD_BITS){1'b0}}, dym_reg};
    assign move_x = (e2 >= dy_w);
    assign move_y = (e2 <= dx_w);

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        ex_next   = ex_reg;
        ey_next   = ey_reg;
        dx_next   = dx_reg;
        dym_next  = dym_reg;
        xneg_next = xneg_reg;
        yneg_next = yneg_reg;
        err_next  = err_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (pop)
        begin
            busy_next = 1'b1;
            cx_next   = cmd.start_x;
            cy_next   = cmd.start_y;
            ex_next   = cmd.end_x;
            ey_next   = cmd.end_y;
            dx_next   = cmd.dx;
            dym_next  = cmd.dy_mag;
            xneg_next = cmd.x_neg;
            yneg_next = cmd.y_neg;
            err_next  = cmd.err0;
        end
        else if (advance)
        begin
            out_valid_next           = 1'b1;
            out_item_next.pixel_x    = cx_reg;
            out_item_next.pixel_y    = cy_reg;
            out_item_next.visible    = (canvas_t'(cx_reg) < canvas_width)
                                    && (canvas_t'(cy_reg) < canvas_height);
            out_item_next.last_pixel = done;
            if (done)
                busy_next = 1'b0;
            else
            begin
                err_next = err_reg + (move_x ? dy_e : '0) + (move_y ? dx_e : '0);
                if (move_x)
                    cx_next = xneg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                if (move_y)
                    cy_next = yneg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        dx_reg   <= dx_next;
        dym_reg  <= dym_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        err_reg  <= err_next;
    end

endmodule

@@ dv/line_rasterizer_tb.sv @@
// Self-checking testbench for the line rasterizer: random and directed lines, scoreboard.
module line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lr_pkg::*;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CANVAS_W-1:0] cfg_data = '0;

    line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    localparam int QUIET_LIMIT = 4000;

    in_item_t  pending_lines[$];
    out_item_t expected_pixels[$];
    int win_w = 60;
    int win_h = 20;
    int n_queued = 0;
    int n_accepted = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int line_gap = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Walk the line with the error-term stepping and queue every pixel it should emit.
    function automatic void trace_line(in_item_t cmd);
        int x, y, ex, ey, dx, dy, sx, sy, err, e2, n;
        bit done;
        out_item_t px;
        x  = cmd.start_x;
        y  = cmd.start_y;
        ex = cmd.end_x;
        ey = cmd.end_y;
        dx = (ex > x) ? ex - x : x - ex;
        dy = (ey > y) ? y - ey : ey - y;
        sx = (x < ex) ? 1 : -1;
        sy = (y < ey) ? 1 : -1;
        err = dx + dy;
        for (n = 0; n < (1 << COORD_BITS); n++)
        begin
            done = (x == ex) && (y == ey);
            px.pixel_x    = coord_t'(x);
            px.pixel_y    = coord_t'(y);
            px.visible    = (x < win_w) && (y < win_h);
            px.last_pixel = done;
            expected_pixels.push_back(px);
            if (done)
                break;
            e2 = 2 * err;
            if (e2 >= dy)
            begin
                err += dy;
                x += sx;
            end
            if (e2 <= dx)
            begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; none while idle_on is clear.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t line_of(int sx, int sy, int ex, int ey);
        in_item_t c;
        c.start_x = coord_t'(sx);
        c.start_y = coord_t'(sy);
        c.end_x   = coord_t'(ex);
        c.end_y   = coord_t'(ey);
        return c;
    endfunction

    function automatic in_item_t random_line();
        in_item_t c;
        int r;
        c = line_of($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 63));
        r = $urandom_range(99);
        if (r < 30)
        begin
            // short line, wraps around the coordinate range now and then
            c.end_x = coord_t'(int'(c.start_x) + $urandom_range(0, 8) - 4);
            c.end_y = coord_t'(int'(c.start_y) + $urandom_range(0, 8) - 4);
        end
        else if (r < 40)
            c.end_y = c.start_y;
        else if (r < 48)
            c.end_x = c.start_x;
        else if (r < 56)
            c.end_y = coord_t'(int'(c.start_y) + int'(c.end_x) - int'(c.start_x));
        else if (r < 60)
        begin
            c.end_x = c.start_x;
            c.end_y = c.start_y;
        end
        return c;
    endfunction

    task automatic queue_line(in_item_t c);
        pending_lines.push_back(c);
        n_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (n_accepted != n_queued || expected_pixels.size() != 0);
        // stepper may still be retiring its last command
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= canvas_t'(val);
        if (idx == REG_CANVAS_WIDTH)
            win_w = val;
        else
            win_h = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Line command driver.
    always @(negedge clk)
    begin : feed
        logic nv;
        in_item_t ni;
        nv = in_valid;
        ni = in_item;
        if (!rst_n)
            nv = 1'b0;
        else if (!in_valid || in_fire)
        begin
            nv = 1'b0;
            if (line_gap > 0)
                line_gap--;
            else if (pending_lines.size() > 0)
            begin
                ni = pending_lines.pop_front();
                nv = 1'b1;
                line_gap = pick_gap();
            end
        end
        in_valid <= nv;
        in_item  <= ni;
    end

    // Pixel sink back-pressure.
    always @(negedge clk)
    begin : sink
        logic st;
        if (stall_left > 0)
        begin
            stall_left--;
            st = 1'b1;
        end
        else
        begin
            st = 1'b0;
            stall_left = pick_gap();
        end
        out_stall <= st;
    end

    // Monitor: predicts on accepted commands, checks accepted pixels, watches for a hang.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (in_fire)
        begin
            trace_line(in_item);
            n_accepted++;
        end
        if (out_fire)
        begin
            if (expected_pixels.size() == 0)
                note_failure($sformatf("unexpected pixel x=%0d y=%0d vis=%0b last=%0b",
                    out_item.pixel_x, out_item.pixel_y, out_item.visible,
                    out_item.last_pixel));
            else
            begin
                want = expected_pixels.pop_front();
                if (out_item !== want)
                    note_failure($sformatf(
                        "exp x=%0d y=%0d vis=%0b last=%0b, got x=%0d y=%0d vis=%0b last=%0b",
                        want.pixel_x, want.pixel_y, want.visible, want.last_pixel,
                        out_item.pixel_x, out_item.pixel_y, out_item.visible,
                        out_item.last_pixel));
            end
        end
        if (in_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int k, i, w, h;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines under the reset window of 60 by 20.
        queue_line(line_of(0, 0, 0, 0));
        queue_line(line_of(63, 63, 63, 63));
        queue_line(line_of(0, 0, 63, 0));
        queue_line(line_of(63, 0, 0, 0));
        queue_line(line_of(0, 0, 0, 63));
        queue_line(line_of(0, 63, 0, 0));
        queue_line(line_of(0, 0, 63, 63));
        queue_line(line_of(63, 63, 0, 0));
        queue_line(line_of(63, 0, 0, 63));
        queue_line(line_of(0, 63, 63, 0));
        queue_line(line_of(10, 10, 40, 20));
        queue_line(line_of(40, 20, 10, 10));
        queue_line(line_of(10, 10, 20, 40));
        queue_line(line_of(20, 40, 10, 10));
        queue_line(line_of(30, 5, 5, 12));
        queue_line(line_of(5, 12, 30, 5));
        queue_line(line_of(12, 30, 5, 50));
        queue_line(line_of(5, 50, 12, 30));
        queue_line(line_of(0, 0, 63, 1));
        queue_line(line_of(0, 0, 1, 63));
        queue_line(line_of(32, 32, 33, 32));
        queue_line(line_of(55, 15, 63, 25));
        queue_line(line_of(59, 19, 60, 20));
        wait_drained();

        // Random phases, each under its own window; the sender drains between them.
        for (k = 0; k < 10; k++)
        begin
            case (k)
                0: begin w = 0;   h = 64;  end
                1: begin w = 64;  h = 0;   end
                2: begin w = 127; h = 127; end
                3: begin w = 1;   h = 1;   end
                4: begin w = 65;  h = 63;  end
                default:
                begin
                    w = ($urandom_range(99) < 20) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 64);
                    h = ($urandom_range(99) < 20) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 64);
                end
            endcase
            write_reg(REG_CANVAS_WIDTH, w);
            write_reg(REG_CANVAS_HEIGHT, h);
            idle_on = (k % 4) != 2;
            for (i = 0; i < 28; i++)
                queue_line(random_line());
            wait_drained();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_queue.sv
hw/rtl/lr_stepper.sv
hw/rtl/line_rasterizer.sv
dv/line_rasterizer_tb.sv
